>>> hdl/bvp_pkg.sv
// bvp_pkg: shared types and constants of the braking velocity profile block
// depends on nothing; imported by the top level
`default_nettype none

package bvp_pkg;

	localparam int IDX_W   = 3;
	localparam int CFG_W   = 31;
	localparam int RATE_W  = 24;
	localparam int DIST_W  = 31;
	localparam int TICK_W  = 16;
	localparam int DIR_W   = 16;
	localparam int THR_W   = 17;
	localparam int DROOT_W = 32;
	localparam int DSQ_W   = 64;
	localparam int BRAD_W  = 56;
	localparam int BROOT_W = 28;
	localparam int QUO_W   = 16;
	localparam int TNUM_W  = 40;
	localparam int DNUM_W  = 48;

	localparam logic [DIST_W-1:0] DIST_MAX  = '1;
	localparam logic [RATE_W-1:0] DECEL_MIN = 24'd256;

	typedef enum logic [IDX_W-1:0] {
		REG_MAX_SPEED     = 3'd0,
		REG_ACCEL_RATE    = 3'd1,
		REG_DECEL_RATE    = 3'd2,
		REG_ARRIVE_RADIUS = 3'd3,
		REG_STOP_SPEED    = 3'd4,
		REG_USE_THREE_D   = 3'd5
	} reg_idx_t;

endpackage

`default_nettype wire

>>> hdl/bvp_sqrt_cell.sv
// bvp_sqrt_cell: one digit of a restoring integer square root
// self-contained; chained by bvp_isqrt
`default_nettype none

module bvp_sqrt_cell #(
	parameter int N = 64,
	parameter int R = 32,
	parameter int I = 0,
	parameter int W = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [N-1:0] in_rem,
	input  logic [R-1:0] in_root,
	input  logic [W-1:0] in_side,
	output logic         out_valid,
	output logic [N-1:0] out_rem,
	output logic [R-1:0] out_root,
	output logic [W-1:0] out_side
);

	logic [N:0] trial;
	logic       take;

	always_comb begin
		trial = ((N+1)'(in_root) << (I + 1)) | ((N+1)'(1) << (2 * I));
		take  = (N+1)'(in_rem) >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_side <= in_side;
		if (take) begin
			out_rem  <= N'(in_rem - trial[N-1:0]);
			out_root <= in_root | (R'(1) << I);
		end else begin
			out_rem  <= in_rem;
			out_root <= in_root;
		end
	end

endmodule

`default_nettype wire

>>> hdl/bvp_isqrt.sv
// bvp_isqrt: chain of square root cells, one root bit per cell per cycle
// depends on bvp_sqrt_cell
`default_nettype none

module bvp_isqrt #(
	parameter int N = 64,
	parameter int R = 32,
	parameter int W = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [N-1:0] in_rad,
	input  logic [W-1:0] in_side,
	output logic         out_valid,
	output logic [R-1:0] out_root,
	output logic [W-1:0] out_side
);

	logic         vld_c  [R+1];
	logic [N-1:0] rem_c  [R+1];
	logic [R-1:0] root_c [R+1];
	logic [W-1:0] side_c [R+1];

	assign vld_c[0]  = in_valid;
	assign rem_c[0]  = in_rad;
	assign root_c[0] = '0;
	assign side_c[0] = in_side;

	for (genvar k = 0; k < R; k++) begin : g_cell
		bvp_sqrt_cell #(.N(N), .R(R), .I(R - 1 - k), .W(W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld_c[k]),
			.in_rem   (rem_c[k]),
			.in_root  (root_c[k]),
			.in_side  (side_c[k]),
			.out_valid(vld_c[k+1]),
			.out_rem  (rem_c[k+1]),
			.out_root (root_c[k+1]),
			.out_side (side_c[k+1])
		);
	end

	assign out_valid = vld_c[R];
	assign out_root  = root_c[R];
	assign out_side  = side_c[R];

endmodule

`default_nettype wire

>>> hdl/bvp_div_cell.sv
// bvp_div_cell: one quotient bit of a restoring divider
// self-contained; chained by bvp_div
`default_nettype none

module bvp_div_cell #(
	parameter int N  = 48,
	parameter int D  = 32,
	parameter int QB = 16,
	parameter int I  = 0,
	parameter int W  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [N-1:0]  in_rem,
	input  logic [D-1:0]  in_den,
	input  logic [QB-1:0] in_quo,
	input  logic [W-1:0]  in_side,
	output logic          out_valid,
	output logic [N-1:0]  out_rem,
	output logic [D-1:0]  out_den,
	output logic [QB-1:0] out_quo,
	output logic [W-1:0]  out_side
);

	logic [N-1:0] den_sh;
	logic         take;

	always_comb begin
		den_sh = N'(in_den) << I;
		take   = in_rem >= den_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_den  <= in_den;
		out_side <= in_side;
		if (take) begin
			out_rem <= in_rem - den_sh;
			out_quo <= in_quo | (QB'(1) << I);
		end else begin
			out_rem <= in_rem;
			out_quo <= in_quo;
		end
	end

endmodule

`default_nettype wire

>>> hdl/bvp_div.sv
// bvp_div: chain of divider cells, one quotient bit per cell per cycle
// depends on bvp_div_cell
`default_nettype none

module bvp_div #(
	parameter int N  = 48,
	parameter int D  = 32,
	parameter int QB = 16,
	parameter int W  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [N-1:0]  in_num,
	input  logic [D-1:0]  in_den,
	input  logic [W-1:0]  in_side,
	output logic          out_valid,
	output logic [QB-1:0] out_quo,
	output logic [W-1:0]  out_side
);

	logic          vld_c  [QB+1];
	logic [N-1:0]  rem_c  [QB+1];
	logic [D-1:0]  den_c  [QB+1];
	logic [QB-1:0] quo_c  [QB+1];
	logic [W-1:0]  side_c [QB+1];

	assign vld_c[0]  = in_valid;
	assign rem_c[0]  = in_num;
	assign den_c[0]  = in_den;
	assign quo_c[0]  = '0;
	assign side_c[0] = in_side;

	for (genvar k = 0; k < QB; k++) begin : g_cell
		bvp_div_cell #(.N(N), .D(D), .QB(QB), .I(QB - 1 - k), .W(W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld_c[k]),
			.in_rem   (rem_c[k]),
			.in_den   (den_c[k]),
			.in_quo   (quo_c[k]),
			.in_side  (side_c[k]),
			.out_valid(vld_c[k+1]),
			.out_rem  (rem_c[k+1]),
			.out_den  (den_c[k+1]),
			.out_quo  (quo_c[k+1]),
			.out_side (side_c[k+1])
		);
	end

	assign out_valid = vld_c[QB];
	assign out_quo   = quo_c[QB];
	assign out_side  = side_c[QB];

endmodule

`default_nettype wire

>>> hdl/braking_velocity_profile.sv
// braking_velocity_profile: trapezoidal speed planner with braking distance
// depends on bvp_pkg, bvp_isqrt, bvp_div
// one item accepted every cycle, busy stays low
// the pipeline runs through the root chains (32 and 28 cells) and the 16-cell divider chains
// the receiver cannot stall: every result shows for one cycle with done
// async reset clears valid bits and loads the register reset values, no clearing pass
`default_nettype none

module braking_velocity_profile #(
	parameter int POSITION_BITS = 32,
	parameter int SPEED_BITS    = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [bvp_pkg::IDX_W-1:0]        wr_index,
	input  logic [bvp_pkg::CFG_W-1:0]        wr_data,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [POSITION_BITS-1:0]  pos_x,
	input  logic signed [POSITION_BITS-1:0]  pos_y,
	input  logic signed [POSITION_BITS-1:0]  pos_z,
	input  logic signed [POSITION_BITS-1:0]  target_x,
	input  logic signed [POSITION_BITS-1:0]  target_y,
	input  logic signed [POSITION_BITS-1:0]  target_z,
	input  logic signed [SPEED_BITS-1:0]     vel_x,
	input  logic signed [SPEED_BITS-1:0]     vel_y,
	input  logic signed [SPEED_BITS-1:0]     vel_z,
	input  logic [bvp_pkg::TICK_W-1:0]       tick_time,
	output logic                             done,
	output logic signed [bvp_pkg::DIR_W-1:0] dir_x,
	output logic signed [bvp_pkg::DIR_W-1:0] dir_y,
	output logic signed [bvp_pkg::DIR_W-1:0] dir_z,
	output logic [bvp_pkg::THR_W-1:0]        throttle,
	output logic [bvp_pkg::DIST_W-1:0]       distance,
	output logic                             arrived
);

	import bvp_pkg::*;

	localparam int P   = POSITION_BITS;
	localparam int S   = SPEED_BITS;
	localparam int MW  = P + 1;                       // delta magnitude width
	localparam int AW  = (MW > DIST_W) ? MW : DIST_W; // width for the pre-root shift
	localparam int SHW = $clog2(MW + 1);
	localparam int VSQ = 2 * S;

	// sideband carried through the chains
	typedef struct packed {
		logic [SHW-1:0]    sh;
		logic [DIST_W-1:0] ax;
		logic [DIST_W-1:0] ay;
		logic [DIST_W-1:0] az;
		logic [TICK_W-1:0] tick;
	} dside_t;

	typedef struct packed {
		logic              brake;
		logic [S-1:0]      speed;
		logic [RATE_W-1:0] stepa;
		logic [RATE_W-1:0] stepd;
		logic [DIST_W-1:0] span;
		logic              arr;
		logic [DROOT_W-1:0] ds;
		logic [DIST_W-1:0] ax;
		logic [DIST_W-1:0] ay;
		logic [DIST_W-1:0] az;
		logic [2:0]        sgn;
	} bside_t;

	typedef struct packed {
		logic [DIST_W-1:0] span;
		logic              arr;
		logic              sat;
		logic              zero;
		logic              dszero;
	} tside_t;

	// configuration registers
	logic [RATE_W-1:0] max_speed_q, accel_rate_q, decel_rate_q, stop_speed_q;
	logic [DIST_W-1:0] arrive_radius_q;
	logic              use_three_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q     <= 24'd153600;
			accel_rate_q    <= 24'd512000;
			decel_rate_q    <= 24'd512000;
			arrive_radius_q <= 31'd12800;
			stop_speed_q    <= 24'd2560;
			use_three_d_q   <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_MAX_SPEED:     max_speed_q     <= wr_data[RATE_W-1:0];
				REG_ACCEL_RATE:    accel_rate_q    <= wr_data[RATE_W-1:0];
				REG_DECEL_RATE:    decel_rate_q    <= wr_data[RATE_W-1:0];
				REG_ARRIVE_RADIUS: arrive_radius_q <= wr_data[DIST_W-1:0];
				REG_STOP_SPEED:    stop_speed_q    <= wr_data[RATE_W-1:0];
				REG_USE_THREE_D:   use_three_d_q   <= wr_data[0];
				default: ;
			endcase
		end
	end

	// every cycle takes an item
	assign busy = 1'b0;

	// valid bits of the glue stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic dv_root, sv_root, bv_root, tv_quo, xv_quo, yv_quo, zv_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= dv_root & sv_root;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= bv_root;
			v_s9 <= v_s8;
			done <= tv_quo & xv_quo & yv_quo & zv_quo;
		end
	end

	// stage 1: deltas and magnitudes, z dropped in planar mode
	logic signed [P:0] dx_c, dy_c, dz_c;
	logic [MW-1:0]     mag_s1 [3];
	logic [2:0]        sgn_s1;
	logic [S-1:0]      vm_s1 [3];
	logic [TICK_W-1:0] tick_s1;

	always_comb begin
		dx_c = {target_x[P-1], target_x} - {pos_x[P-1], pos_x};
		dy_c = {target_y[P-1], target_y} - {pos_y[P-1], pos_y};
		dz_c = use_three_d_q ? ({target_z[P-1], target_z} - {pos_z[P-1], pos_z}) : '0;
	end

	always_ff @(posedge clk) begin
		sgn_s1    <= {dz_c[P], dy_c[P], dx_c[P]};
		mag_s1[0] <= dx_c[P] ? MW'(-dx_c) : MW'(dx_c);
		mag_s1[1] <= dy_c[P] ? MW'(-dy_c) : MW'(dy_c);
		mag_s1[2] <= dz_c[P] ? MW'(-dz_c) : MW'(dz_c);
		vm_s1[0]  <= vel_x[S-1] ? S'(-vel_x) : S'(vel_x);
		vm_s1[1]  <= vel_y[S-1] ? S'(-vel_y) : S'(vel_y);
		vm_s1[2]  <= (use_three_d_q && vel_z[S-1]) ? S'(-vel_z) :
		             (use_three_d_q ? S'(vel_z) : '0);
		tick_s1   <= tick_time;
	end

	// stage 2: common right shift so every component fits 31 bits
	logic [MW-1:0]     mx_c;
	logic [SHW-1:0]    blen_c, sh_c;
	logic [DIST_W-1:0] a_s2 [3];
	logic [SHW-1:0]    sh_s2;
	logic [2:0]        sgn_s2;
	logic [S-1:0]      vm_s2 [3];
	logic [TICK_W-1:0] tick_s2;

	always_comb begin
		mx_c = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];
		if (mag_s1[2] > mx_c) begin
			mx_c = mag_s1[2];
		end
		blen_c = '0;
		for (int i = 0; i < MW; i++) begin
			if (mx_c[i]) begin
				blen_c = SHW'(i + 1);
			end
		end
		sh_c = (blen_c > SHW'(DIST_W)) ? SHW'(blen_c - SHW'(DIST_W)) : '0;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			a_s2[i]  <= DIST_W'(AW'(mag_s1[i]) >> sh_c);
			vm_s2[i] <= vm_s1[i];
		end
		sh_s2   <= sh_c;
		sgn_s2  <= sgn_s1;
		tick_s2 <= tick_s1;
	end

	// stage 3: squares
	logic [2*DIST_W-1:0] dsq_s3 [3];
	logic [VSQ-1:0]      vsq_s3 [3];
	logic [DIST_W-1:0]   a_s3 [3];
	logic [SHW-1:0]      sh_s3;
	logic [2:0]          sgn_s3;
	logic [TICK_W-1:0]   tick_s3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dsq_s3[i] <= (2*DIST_W)'(a_s2[i]) * (2*DIST_W)'(a_s2[i]);
			vsq_s3[i] <= VSQ'(vm_s2[i]) * VSQ'(vm_s2[i]);
			a_s3[i]   <= a_s2[i];
		end
		sh_s3   <= sh_s2;
		sgn_s3  <= sgn_s2;
		tick_s3 <= tick_s2;
	end

	// stage 4: sums of squares
	logic [DSQ_W-1:0] sumd_s4, sumv_s4;
	dside_t           dside_s4;
	logic [2:0]       sgn_s4;

	always_ff @(posedge clk) begin
		sumd_s4 <= DSQ_W'(dsq_s3[0]) + DSQ_W'(dsq_s3[1]) + DSQ_W'(dsq_s3[2]);
		sumv_s4 <= DSQ_W'(VSQ'(vsq_s3[0] + vsq_s3[1] + vsq_s3[2]));
		dside_s4 <= '{sh: sh_s3, ax: a_s3[0], ay: a_s3[1], az: a_s3[2], tick: tick_s3};
		sgn_s4  <= sgn_s3;
	end

	// distance and speed roots run side by side
	logic [DROOT_W-1:0] droot, sroot;
	dside_t             dside_r;
	logic [2:0]         sgn_r;

	bvp_isqrt #(.N(DSQ_W), .R(DROOT_W), .W($bits(dside_t))) u_dist_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.in_rad   (sumd_s4),
		.in_side  (dside_s4),
		.out_valid(dv_root),
		.out_root (droot),
		.out_side (dside_r)
	);

	bvp_isqrt #(.N(DSQ_W), .R(DROOT_W), .W(3)) u_speed_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.in_rad   (sumv_s4),
		.in_side  (sgn_s4),
		.out_valid(sv_root),
		.out_root (sroot),
		.out_side (sgn_r)
	);

	// stage 5: distance shifted back and saturated, safe distance, arrival
	logic [DSQ_W-1:0]   dwide_c;
	logic [DIST_W-1:0]  dist_c;
	logic [S-1:0]       speed_c;
	logic [DIST_W-1:0]  dist_s5, safe_s5;
	logic               arr_s5;
	logic [S-1:0]       speed_s5;
	logic [DROOT_W-1:0] ds_s5;
	logic [DIST_W-1:0]  a_s5 [3];
	logic [2:0]         sgn_s5;
	logic [TICK_W-1:0]  tick_s5;

	always_comb begin
		dwide_c = DSQ_W'(droot) << dside_r.sh;
		dist_c  = (dwide_c > DSQ_W'(DIST_MAX)) ? DIST_MAX : dwide_c[DIST_W-1:0];
		speed_c = sroot[S-1:0];
	end

	always_ff @(posedge clk) begin
		dist_s5  <= dist_c;
		safe_s5  <= (dist_c > arrive_radius_q) ? dist_c - arrive_radius_q : '0;
		arr_s5   <= (dist_c <= arrive_radius_q) && (32'(speed_c) <= 32'(stop_speed_q));
		speed_s5 <= speed_c;
		ds_s5    <= droot;
		a_s5[0]  <= dside_r.ax;
		a_s5[1]  <= dside_r.ay;
		a_s5[2]  <= dside_r.az;
		sgn_s5   <= sgn_r;
		tick_s5  <= dside_r.tick;
	end

	// stage 6: braking product, speed squared, rate steps for both directions
	localparam int PW = DIST_W + RATE_W;
	logic [RATE_W-1:0]  sdec_c;
	logic [PW-1:0]      prod_s6;
	logic [VSQ-1:0]     spsq_s6;
	logic [RATE_W-1:0]  stepa_s6, stepd_s6;
	logic [DIST_W-1:0]  dist_s6;
	logic               arr_s6;
	logic [S-1:0]       speed_s6;
	logic [DROOT_W-1:0] ds_s6;
	logic [DIST_W-1:0]  a_s6 [3];
	logic [2:0]         sgn_s6;
	logic [RATE_W+TICK_W-1:0] stepa_c, stepd_c;

	always_comb begin
		// braking math never uses a rate below one
		sdec_c  = (decel_rate_q < DECEL_MIN) ? DECEL_MIN : decel_rate_q;
		stepa_c = (RATE_W+TICK_W)'(accel_rate_q) * (RATE_W+TICK_W)'(tick_s5);
		stepd_c = (RATE_W+TICK_W)'(decel_rate_q) * (RATE_W+TICK_W)'(tick_s5);
	end

	always_ff @(posedge clk) begin
		prod_s6  <= PW'(safe_s5) * PW'(sdec_c);
		spsq_s6  <= VSQ'(speed_s5) * VSQ'(speed_s5);
		stepa_s6 <= stepa_c[RATE_W+TICK_W-1:TICK_W];
		stepd_s6 <= stepd_c[RATE_W+TICK_W-1:TICK_W];
		dist_s6  <= dist_s5;
		arr_s6   <= arr_s5;
		speed_s6 <= speed_s5;
		ds_s6    <= ds_s5;
		a_s6     <= a_s5;
		sgn_s6   <= sgn_s5;
	end

	// stage 7: inside the braking distance when 2*decel*d <= speed^2
	logic [BRAD_W-1:0] two_c;
	logic              brake_c;
	logic [BRAD_W-1:0] rad_s7;
	bside_t            bside_s7;

	always_comb begin
		two_c   = {prod_s6, 1'b0};
		brake_c = DSQ_W'(two_c) <= DSQ_W'(spsq_s6);
	end

	always_ff @(posedge clk) begin
		rad_s7   <= brake_c ? two_c : '0;
		bside_s7 <= '{brake: brake_c, speed: speed_s6, stepa: stepa_s6, stepd: stepd_s6,
		              span: dist_s6, arr: arr_s6, ds: ds_s6, ax: a_s6[0], ay: a_s6[1],
		              az: a_s6[2], sgn: sgn_s6};
	end

	// braking speed root
	logic [BROOT_W-1:0] broot;
	bside_t             bside_r;

	bvp_isqrt #(.N(BRAD_W), .R(BROOT_W), .W($bits(bside_t))) u_brake_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s7),
		.in_rad   (rad_s7),
		.in_side  (bside_s7),
		.out_valid(bv_root),
		.out_root (broot),
		.out_side (bside_r)
	);

	// stage 8: step the speed toward the desired speed
	logic [31:0]        des_c, spd_c, diff_c, stp_c, ns_c;
	logic               gt_c, rzero_c;
	logic [31:0]        ns_s8;
	logic [DIST_W-1:0]  dist_s8;
	logic               arr_s8;
	logic [DROOT_W-1:0] ds_s8;
	logic [DIST_W-1:0]  a_s8 [3];
	logic [2:0]         sgn_s8;

	always_comb begin
		des_c   = bside_r.brake ? 32'(broot) : 32'(max_speed_q);
		spd_c   = 32'(bside_r.speed);
		gt_c    = des_c > spd_c;
		rzero_c = gt_c ? (accel_rate_q == '0) : (decel_rate_q == '0);
		stp_c   = gt_c ? 32'(bside_r.stepa) : 32'(bside_r.stepd);
		diff_c  = gt_c ? des_c - spd_c : spd_c - des_c;
		if (diff_c > stp_c) begin
			diff_c = stp_c;
		end
		if (rzero_c) begin
			// no rate means a jump straight to the desired speed
			ns_c = des_c;
		end else if (gt_c) begin
			ns_c = spd_c + diff_c;
		end else begin
			ns_c = spd_c - diff_c;
		end
	end

	always_ff @(posedge clk) begin
		ns_s8   <= ns_c;
		dist_s8 <= bside_r.span;
		arr_s8  <= bside_r.arr;
		ds_s8   <= bside_r.ds;
		a_s8[0] <= bside_r.ax;
		a_s8[1] <= bside_r.ay;
		a_s8[2] <= bside_r.az;
		sgn_s8  <= bside_r.sgn;
	end

	// stage 9: divider operands; throttle saturates once new speed reaches max
	logic               sat_c, mzero_c;
	logic [TNUM_W-1:0]  tnum_s9;
	logic [DNUM_W-1:0]  dnum_s9 [3];
	logic [DROOT_W-1:0] ds_s9;
	logic [2:0]         sgn_s9;
	tside_t             tside_s9;

	always_comb begin
		sat_c   = ns_s8 >= 32'(max_speed_q);
		mzero_c = max_speed_q == '0;
	end

	always_ff @(posedge clk) begin
		tnum_s9 <= (sat_c || mzero_c) ? '0 : {ns_s8[RATE_W-1:0], 16'b0};
		for (int i = 0; i < 3; i++) begin
			// rounded quotient: add half the divisor first
			dnum_s9[i] <= {2'b0, a_s8[i], 15'b0} + DNUM_W'(ds_s8 >> 1);
		end
		ds_s9    <= ds_s8;
		sgn_s9   <= sgn_s8;
		tside_s9 <= '{span: dist_s8, arr: arr_s8, sat: sat_c, zero: mzero_c,
		              dszero: (ds_s8 == '0)};
	end

	// throttle and direction dividers run side by side
	logic [QUO_W-1:0] tq, xq, yq, zq;
	tside_t           tside_r;
	logic             xs_r, ys_r, zs_r;

	bvp_div #(.N(TNUM_W), .D(RATE_W), .QB(QUO_W), .W($bits(tside_t))) u_thr_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s9),
		.in_num   (tnum_s9),
		.in_den   (max_speed_q),
		.in_side  (tside_s9),
		.out_valid(tv_quo),
		.out_quo  (tq),
		.out_side (tside_r)
	);

	bvp_div #(.N(DNUM_W), .D(DROOT_W), .QB(QUO_W), .W(1)) u_dirx_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s9),
		.in_num   (dnum_s9[0]),
		.in_den   (ds_s9),
		.in_side  (sgn_s9[0]),
		.out_valid(xv_quo),
		.out_quo  (xq),
		.out_side (xs_r)
	);

	bvp_div #(.N(DNUM_W), .D(DROOT_W), .QB(QUO_W), .W(1)) u_diry_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s9),
		.in_num   (dnum_s9[1]),
		.in_den   (ds_s9),
		.in_side  (sgn_s9[1]),
		.out_valid(yv_quo),
		.out_quo  (yq),
		.out_side (ys_r)
	);

	bvp_div #(.N(DNUM_W), .D(DROOT_W), .QB(QUO_W), .W(1)) u_dirz_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s9),
		.in_num   (dnum_s9[2]),
		.in_den   (ds_s9),
		.in_side  (sgn_s9[2]),
		.out_valid(zv_quo),
		.out_quo  (zq),
		.out_side (zs_r)
	);

	// signed direction component, clamped to the q1.15 range
	function automatic logic [DIR_W-1:0] dir_of(input logic [QUO_W-1:0] q, input logic neg);
		logic [QUO_W-1:0] c;
		if (neg) begin
			c = (q > 16'h8000) ? 16'h8000 : q;
			return DIR_W'(~c + 16'd1);
		end
		c = (q > 16'h7FFF) ? 16'h7FFF : q;
		return DIR_W'(c);
	endfunction

	// output register
	always_ff @(posedge clk) begin
		if (tside_r.zero) begin
			throttle <= '0;
		end else if (tside_r.sat) begin
			throttle <= THR_W'(17'h10000);
		end else begin
			throttle <= THR_W'(tq);
		end
		distance <= tside_r.span;
		arrived  <= tside_r.arr;
		// zero distance gives a zero direction
		dir_x <= tside_r.dszero ? '0 : dir_of(xq, xs_r);
		dir_y <= tside_r.dszero ? '0 : dir_of(yq, ys_r);
		dir_z <= tside_r.dszero ? '0 : dir_of(zq, zs_r);
	end

endmodule

`default_nettype wire
